/* rtl/gsst_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, field layout and types for the GPS sector split timer.
// No dependencies; imported by gps_sector_split_timer.
package gsst_pkg;

  // Widths of the timing and averaging state.
  localparam int TIME_BITS    = 48;
  localparam int COUNT_BITS   = 24;
  localparam int SPEED_BITS   = 16;
  localparam int SUM_BITS     = COUNT_BITS + SPEED_BITS;

  // Coordinate and window widths.
  localparam int LAT_BITS     = 31;
  localparam int LON_BITS     = 32;
  localparam int WIN_BITS     = 16;
  localparam int DIFF_BITS    = LON_BITS + 2;
  localparam int SECTOR_BITS  = 2;

  // Marker compare sequence: one step per axis per sector.
  localparam int NUM_SECTORS  = 3;
  localparam int MATCH_STEPS  = 2 * NUM_SECTORS;
  localparam int STEP_BITS    = $clog2(MATCH_STEPS);
  localparam logic [STEP_BITS-1:0] MATCH_LAST = STEP_BITS'(MATCH_STEPS - 1);

  // Divider: the mean never exceeds the largest speed, so it has SPEED_BITS bits.
  localparam int DIV_CNT_BITS = $clog2(SPEED_BITS);

  // Input tdata layout, lowest bit first.
  localparam int LAT_LO       = 0;
  localparam int LON_LO       = LAT_LO + LAT_BITS;
  localparam int SPD_LO       = LON_LO + LON_BITS;
  localparam int TS_LO        = SPD_LO + SPEED_BITS;
  localparam int IN_USED_BITS = TS_LO + TIME_BITS;
  localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_USED_BITS = SECTOR_BITS + TIME_BITS + SPEED_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  // Request kinds carried on in_tuser.
  localparam logic REQ_SPEED = 1'b0;
  localparam logic REQ_FIX   = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_S1_LAT = 3'd0,
    REG_S1_LON = 3'd1,
    REG_S2_LAT = 3'd2,
    REG_S2_LON = 3'd3,
    REG_S3_LAT = 3'd4,
    REG_S3_LON = 3'd5,
    REG_WINDOW = 3'd6
  } cfg_reg_t;

  // Reset values of the marker registers and the match window.
  localparam logic signed [LAT_BITS-1:0] RST_S1_LAT = 31'sd456301060;
  localparam logic signed [LON_BITS-1:0] RST_S1_LON = 32'sd92894900;
  localparam logic signed [LAT_BITS-1:0] RST_S2_LAT = 31'sd456235700;
  localparam logic signed [LON_BITS-1:0] RST_S2_LON = 32'sd92872970;
  localparam logic signed [LAT_BITS-1:0] RST_S3_LAT = 31'sd456160420;
  localparam logic signed [LON_BITS-1:0] RST_S3_LON = 32'sd92807670;
  localparam logic [WIN_BITS-1:0]        RST_WINDOW = 16'd500;

  // Sector numbering as it appears on the output.
  localparam logic [SECTOR_BITS-1:0] SECTOR_ONE = 2'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

/* rtl/gps_sector_split_timer.sv */
`timescale 1ns / 1ps
// GPS sector split timer: marker matching, sector clock and mean speed.
// Depends on gsst_pkg for widths, field layout, register codes and states.
//
// Timing: a speed update is taken and gives no result. A fix runs the marker
// compares on one shared subtract/compare unit, an update step and a restoring
// divider (one quotient bit per cycle) before its result is registered; no new
// item is taken until that result is loaded into the output register, which
// waits while a still pending result has not been taken.
// Reset (rst_n low, synchronous) restores the default markers and window,
// sector one, and zero entry time, count, sum and latest speed.
module gps_sector_split_timer
  import gsst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // Input stream.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // in_tdata: latitude[30:0], longitude[62:31], speed[78:63], timestamp[126:79], zero
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // in_tuser: req_type (0 speed update, 1 fix)
  input  logic                     in_tuser,
  // Result stream.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // out_tdata: sector[1:0], sector_time[49:2], mean_speed[65:50], zero
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  // Sequencer.
  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [LAT_BITS-1:0] mark_lat_r [NUM_SECTORS];
  logic signed [LON_BITS-1:0] mark_lon_r [NUM_SECTORS];
  logic [WIN_BITS-1:0]        window_r;

  // Tracking state.
  logic [SECTOR_BITS-1:0] sector_r;
  logic [TIME_BITS-1:0]   entry_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [SPEED_BITS-1:0]  latest_speed_r;

  // Fix being processed.
  logic signed [LAT_BITS-1:0] fix_lat_r;
  logic signed [LON_BITS-1:0] fix_lon_r;
  logic [TIME_BITS-1:0]       fix_time_r;

  // Marker compare sequence.
  logic [STEP_BITS-1:0]   step_r;
  logic                   lat_ok_r;
  logic                   found_r;
  logic [SECTOR_BITS-1:0] found_sec_r;

  // Divider and result.
  logic [COUNT_BITS-1:0]   rem_r;
  logic [SPEED_BITS-1:0]   quo_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [TIME_BITS-1:0]    sec_time_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  // Handshake and control decodes.
  logic in_xfer, fix_xfer, speed_xfer, emit_load;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (fix_xfer) state_nxt = ST_MATCH;
      ST_MATCH:  if (step_r == MATCH_LAST) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (div_cnt_r == '0) state_nxt = ST_EMIT;
      ST_EMIT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  end

  assign in_xfer    = in_tvalid && in_tready;
  assign fix_xfer   = in_xfer && (in_tuser == REQ_FIX);
  assign speed_xfer = in_xfer && (in_tuser == REQ_SPEED);

  // Shared compare unit: |fix axis - marker axis| < window, one axis per cycle.
  logic [1:0]                  sec_idx;
  logic                        axis_lon;
  logic signed [DIFF_BITS-1:0] op_a, op_b, diff, mag;
  logic                        near;

  assign sec_idx  = step_r[STEP_BITS-1:1];
  assign axis_lon = step_r[0];

  always_comb begin
    logic signed [LAT_BITS-1:0] m_lat;
    logic signed [LON_BITS-1:0] m_lon;
    case (sec_idx)
      2'd0:    begin m_lat = mark_lat_r[0]; m_lon = mark_lon_r[0]; end
      2'd1:    begin m_lat = mark_lat_r[1]; m_lon = mark_lon_r[1]; end
      2'd2:    begin m_lat = mark_lat_r[2]; m_lon = mark_lon_r[2]; end
      default: begin m_lat = '0;            m_lon = '0;            end
    endcase
    if (axis_lon) begin
      op_a = {{(DIFF_BITS-LON_BITS){fix_lon_r[LON_BITS-1]}}, fix_lon_r};
      op_b = {{(DIFF_BITS-LON_BITS){m_lon[LON_BITS-1]}}, m_lon};
    end else begin
      op_a = {{(DIFF_BITS-LAT_BITS){fix_lat_r[LAT_BITS-1]}}, fix_lat_r};
      op_b = {{(DIFF_BITS-LAT_BITS){m_lat[LAT_BITS-1]}}, m_lat};
    end
    diff = op_a - op_b;
    mag  = diff[DIFF_BITS-1] ? -diff : diff;
    near = ($unsigned(mag) < {{(DIFF_BITS-WIN_BITS){1'b0}}, window_r});
  end

  // Sector entry, sample accumulation and elapsed time for the fix.
  logic                   enter;
  logic [SECTOR_BITS-1:0] sector_new;
  logic [TIME_BITS-1:0]   entry_new, time_new;
  logic [COUNT_BITS-1:0]  count_base, count_new;
  logic [SUM_BITS-1:0]    sum_base, sum_new;

  always_comb begin
    enter      = found_r && (found_sec_r != sector_r);
    sector_new = enter ? found_sec_r : sector_r;
    entry_new  = enter ? fix_time_r : entry_r;
    count_base = enter ? '0 : count_r;
    sum_base   = enter ? '0 : sum_r;
    // A full count freezes both the count and the sum.
    if (&count_base) begin
      count_new = count_base;
      sum_new   = sum_base;
    end else begin
      count_new = count_base + COUNT_BITS'(1);
      sum_new   = sum_base + SUM_BITS'(latest_speed_r);
    end
    time_new = fix_time_r - entry_new;
  end

  // One restoring division step: shift in the next dividend bit, try a subtract.
  logic [COUNT_BITS:0] rem_sh, rem_sub;
  logic                rem_ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SPEED_BITS-1]};
    rem_sub = rem_sh - {1'b0, count_r};
    rem_ge  = (rem_sh >= {1'b0, count_r});
  end

  // Result register holds until the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control, configuration and tracking registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      mark_lat_r[0]  <= RST_S1_LAT;
      mark_lon_r[0]  <= RST_S1_LON;
      mark_lat_r[1]  <= RST_S2_LAT;
      mark_lon_r[1]  <= RST_S2_LON;
      mark_lat_r[2]  <= RST_S3_LAT;
      mark_lon_r[2]  <= RST_S3_LON;
      window_r       <= RST_WINDOW;
      sector_r       <= SECTOR_ONE;
      entry_r        <= '0;
      count_r        <= '0;
      sum_r          <= '0;
      latest_speed_r <= '0;
      step_r         <= '0;
      lat_ok_r       <= 1'b0;
      found_r        <= 1'b0;
      found_sec_r    <= SECTOR_ONE;
      div_cnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Configuration writes; unknown indexes are ignored.
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_S1_LAT: mark_lat_r[0] <= cfg_data[LAT_BITS-1:0];
          REG_S1_LON: mark_lon_r[0] <= cfg_data[LON_BITS-1:0];
          REG_S2_LAT: mark_lat_r[1] <= cfg_data[LAT_BITS-1:0];
          REG_S2_LON: mark_lon_r[1] <= cfg_data[LON_BITS-1:0];
          REG_S3_LAT: mark_lat_r[2] <= cfg_data[LAT_BITS-1:0];
          REG_S3_LON: mark_lon_r[2] <= cfg_data[LON_BITS-1:0];
          REG_WINDOW: window_r      <= cfg_data[WIN_BITS-1:0];
          default: ;
        endcase
      end

      // A speed update only replaces the latest speed.
      if (speed_xfer) latest_speed_r <= in_tdata[SPD_LO +: SPEED_BITS];

      // Start of the marker compare sequence.
      if (fix_xfer) begin
        step_r   <= '0;
        lat_ok_r <= 1'b0;
        found_r  <= 1'b0;
      end

      // First sector whose markers match on both axes wins.
      if (state_r == ST_MATCH) begin
        step_r <= step_r + STEP_BITS'(1);
        if (!axis_lon) begin
          lat_ok_r <= near;
        end else if (lat_ok_r && near && !found_r) begin
          found_r     <= 1'b1;
          found_sec_r <= SECTOR_BITS'(sec_idx) + SECTOR_BITS'(1);
        end
      end

      if (state_r == ST_UPDATE) begin
        sector_r  <= sector_new;
        entry_r   <= entry_new;
        count_r   <= count_new;
        sum_r     <= sum_new;
        div_cnt_r <= DIV_CNT_BITS'(SPEED_BITS - 1);
      end

      if (state_r == ST_DIVIDE) div_cnt_r <= div_cnt_r - DIV_CNT_BITS'(1);
    end
  end

  // Payload registers: captured fix, divider and result data.
  always_ff @(posedge clk) begin
    if (fix_xfer) begin
      fix_lat_r  <= in_tdata[LAT_LO +: LAT_BITS];
      fix_lon_r  <= in_tdata[LON_LO +: LON_BITS];
      fix_time_r <= in_tdata[TS_LO +: TIME_BITS];
    end

    // The upper dividend bits start as the partial remainder; the sum never
    // reaches count times 2^SPEED_BITS, so it is already below the count.
    if (state_r == ST_UPDATE) begin
      rem_r      <= sum_new[SUM_BITS-1:SPEED_BITS];
      quo_r      <= sum_new[SPEED_BITS-1:0];
      sec_time_r <= time_new;
    end

    if (state_r == ST_DIVIDE) begin
      rem_r <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo_r <= {quo_r[SPEED_BITS-2:0], rem_ge};
    end

    if (emit_load) begin
      out_data_r <= {{(OUT_DATA_BITS-OUT_USED_BITS){1'b0}}, quo_r, sec_time_r, sector_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
